// ----- rtl/lds_pkg.sv -----
package lds_pkg;

    // default operand width in bits
    localparam int DATA_WIDTH_DEF = 32;

    // field widths of the item formats
    localparam int FIELD_W  = 32;
    localparam int RESULT_W = 64;

    // input item: a*x + b*y = n
    typedef struct packed {
        logic signed [FIELD_W-1:0] coef_a;
        logic signed [FIELD_W-1:0] coef_b;
        logic signed [FIELD_W-1:0] target;
    } t_in;

    // result item
    typedef struct packed {
        logic                       solvable;
        logic signed [RESULT_W-1:0] sol_x;
        logic signed [RESULT_W-1:0] sol_y;
    } t_out;

endpackage

// ----- rtl/lds_div.sv -----
module lds_div #(
    parameter int DATA_WIDTH = lds_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quo,
    output logic [DATA_WIDTH-1:0] o_rem
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W);

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_ALIGN = 3'b010,
        D_SUB   = 3'b100
    } t_dstate;

    t_dstate       r_state;
    t_dstate       n_state;
    logic          r_done;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_dvs;
    logic [W-1:0]  r_quo;
    logic [CW-1:0] r_cnt;
    logic          can_shift;
    logic          rem_ge;

    // divisor can move up one more place without passing the remainder
    assign can_shift = !r_dvs[W-1] && ({r_dvs, 1'b0} <= {1'b0, r_rem});
    assign rem_ge    = (r_rem >= r_dvs);

    // sequencer: align the divisor, then one quotient bit per cycle
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) n_state = D_ALIGN;
            end
            D_ALIGN: begin
                if (!can_shift) n_state = D_SUB;
            end
            D_SUB: begin
                if (r_cnt == '0) n_state = D_IDLE;
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == D_SUB) && (r_cnt == '0);
        end
    end

    // shift-subtract datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_rem <= i_dividend;
                    r_dvs <= i_divisor;
                    r_quo <= '0;
                    r_cnt <= '0;
                end
            end
            D_ALIGN: begin
                if (can_shift) begin
                    r_dvs <= {r_dvs[W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            D_SUB: begin
                if (rem_ge) r_rem <= r_rem - r_dvs;
                r_quo <= {r_quo[W-2:0], rem_ge};
                if (r_cnt != '0) begin
                    r_dvs <= {1'b0, r_dvs[W-1:1]};
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    // a new division only starts when the unit is free
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == D_IDLE))
        else $error("divider started while busy");

    // done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");

    // a finished division leaves a remainder below the divisor
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("divider remainder not reduced");
`endif

endmodule

// ----- rtl/lds_mul.sv -----
module lds_mul #(
    parameter int DATA_WIDTH = lds_pkg::DATA_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic [DATA_WIDTH-1:0]   i_op_a,
    input  logic [DATA_WIDTH-1:0]   i_op_b,
    output logic [2*DATA_WIDTH-1:0] o_prod
);

    logic [2*DATA_WIDTH-1:0] r_prod;

    // unsigned magnitude product, registered
    always_ff @(posedge i_clk) begin
        r_prod <= (2*DATA_WIDTH)'(i_op_a) * (2*DATA_WIDTH)'(i_op_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/linear_diophantine_solver.sv -----
// Solves a*x + b*y = n for signed DATA_WIDTH-bit a, b and n (the low DATA_WIDTH bits of each
// field, two's complement) and returns one integer pair as exact 64-bit values, with solvable
// low and both values zero when no pair exists. One item is processed at a time: the input is
// not ready from acceptance until the result has been taken. The work runs through one shared
// shift-subtract divider and one registered multiplier: each extended Euclid step costs one
// division and a coefficient update through S_MS, S_MT and S_UPD, and the final scaling adds one
// division and the multiply states S_MX, S_MY and S_MD. No clearing pass is needed after reset.
module linear_diophantine_solver #(
    parameter int DATA_WIDTH = lds_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lds_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lds_pkg::t_out o_out
);

    localparam int W  = DATA_WIDTH;
    localparam int RW = lds_pkg::RESULT_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_SETUP = 10'b00_0000_0010,
        S_DIVW  = 10'b00_0000_0100,
        S_MS    = 10'b00_0000_1000,
        S_MT    = 10'b00_0001_0000,
        S_UPD   = 10'b00_0010_0000,
        S_MX    = 10'b00_0100_0000,
        S_MY    = 10'b00_1000_0000,
        S_MD    = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        MODE_SINGLE_X,
        MODE_SINGLE_Y,
        MODE_EUCLID,
        MODE_SCALE
    } t_mode;

    t_state         r_state;
    t_state         n_state;
    t_mode          r_mode;

    // operand signs and magnitudes
    logic           r_a_neg;
    logic           r_b_neg;
    logic           r_n_neg;
    logic [W-1:0]   r_a_mag;
    logic [W-1:0]   r_b_mag;
    logic [W-1:0]   r_n_mag;

    // euclid state: current divisor, last quotient/remainder, coefficient magnitudes
    logic [W-1:0]   r_lo;
    logic [W-1:0]   r_quo;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_sm_prev;
    logic [W-1:0]   r_sm_cur;
    logic [W-1:0]   r_tm_prev;
    logic [W-1:0]   r_tm_cur;
    logic           r_par;
    logic [W-1:0]   r_k;

    // result register
    logic           r_ok;
    logic [RW-1:0]  r_x;
    logic [RW-1:0]  r_y;

    logic [W-1:0]   in_a;
    logic [W-1:0]   in_b;
    logic [W-1:0]   in_n;
    logic           a_zero;
    logic           b_zero;

    logic           div_start;
    logic [W-1:0]   div_dvd;
    logic [W-1:0]   div_dvs;
    logic           div_done;
    logic [W-1:0]   div_quo;
    logic [W-1:0]   div_rem;

    logic [W-1:0]   mul_a;
    logic [W-1:0]   mul_b;
    logic [2*W-1:0] mul_prod;

    logic [RW-1:0]  quo_ext;
    logic [RW-1:0]  prod_ext;
    logic           x_neg;
    logic           y_neg;
    logic           q_neg_x;
    logic           q_neg_y;

    // low bits of each field, two's complement
    assign in_a = i_in.coef_a[W-1:0];
    assign in_b = i_in.coef_b[W-1:0];
    assign in_n = i_in.target[W-1:0];

    assign a_zero = (r_a_mag == '0);
    assign b_zero = (r_b_mag == '0);

    // coefficient signs alternate with the remainder index
    assign x_neg   = ~r_par ^ r_n_neg ^ r_a_neg;
    assign y_neg   =  r_par ^ r_n_neg ^ r_b_neg;
    assign q_neg_x = r_n_neg ^ r_a_neg;
    assign q_neg_y = r_n_neg ^ r_b_neg;

    assign quo_ext  = RW'(div_quo);
    assign prod_ext = RW'(mul_prod);

    // divider operand selection
    always_comb begin
        div_start = 1'b0;
        div_dvd   = r_lo;
        div_dvs   = r_rem;
        unique case (r_state)
            S_SETUP: begin
                div_start = !(a_zero && b_zero);
                if (a_zero) begin
                    div_dvd = r_n_mag;
                    div_dvs = r_b_mag;
                end else if (b_zero) begin
                    div_dvd = r_n_mag;
                    div_dvs = r_a_mag;
                end else begin
                    div_dvd = r_b_mag;
                    div_dvs = r_a_mag;
                end
            end
            S_DIVW: begin
                div_start = div_done && (r_mode == MODE_EUCLID) && (div_rem == '0);
                div_dvd   = r_n_mag;
                div_dvs   = r_lo;
            end
            S_UPD: begin
                div_start = 1'b1;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // multiplier operand selection
    always_comb begin
        unique case (r_state)
            S_MS: begin
                mul_a = r_quo;
                mul_b = r_sm_cur;
            end
            S_MT: begin
                mul_a = r_quo;
                mul_b = r_tm_cur;
            end
            S_MX: begin
                mul_a = r_sm_cur;
                mul_b = r_k;
            end
            S_MY: begin
                mul_a = r_tm_cur;
                mul_b = r_k;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = (a_zero && b_zero) ? S_OUT : S_DIVW;
            end
            S_DIVW: begin
                if (div_done) begin
                    unique case (r_mode) inside
                        MODE_SINGLE_X, MODE_SINGLE_Y: n_state = S_OUT;
                        MODE_EUCLID: n_state = (div_rem == '0) ? S_DIVW : S_MS;
                        MODE_SCALE:  n_state = (div_rem == '0) ? S_MX : S_OUT;
                        default:     n_state = S_OUT;
                    endcase
                end
            end
            S_MS:  n_state = S_MT;
            S_MT:  n_state = S_UPD;
            S_UPD: n_state = S_DIVW;
            S_MX:  n_state = S_MY;
            S_MY:  n_state = S_MD;
            S_MD:  n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_a_neg <= in_a[W-1];
                    r_b_neg <= in_b[W-1];
                    r_n_neg <= in_n[W-1];
                    r_a_mag <= in_a[W-1] ? (~in_a + 1'b1) : in_a;
                    r_b_mag <= in_b[W-1] ? (~in_b + 1'b1) : in_b;
                    r_n_mag <= in_n[W-1] ? (~in_n + 1'b1) : in_n;
                end
            end
            S_SETUP: begin
                r_ok      <= a_zero && b_zero && (r_n_mag == '0);
                r_x       <= '0;
                r_y       <= '0;
                r_lo      <= r_a_mag;
                r_sm_prev <= '0;
                r_sm_cur  <= W'(1);
                r_tm_prev <= W'(1);
                r_tm_cur  <= '0;
                r_par     <= 1'b1;
                if (a_zero) begin
                    r_mode <= MODE_SINGLE_Y;
                end else if (b_zero) begin
                    r_mode <= MODE_SINGLE_X;
                end else begin
                    r_mode <= MODE_EUCLID;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    unique case (r_mode)
                        MODE_SINGLE_X: begin
                            if (div_rem == '0) begin
                                r_ok <= 1'b1;
                                r_x  <= q_neg_x ? (RW'(0) - quo_ext) : quo_ext;
                            end
                        end
                        MODE_SINGLE_Y: begin
                            if (div_rem == '0) begin
                                r_ok <= 1'b1;
                                r_y  <= q_neg_y ? (RW'(0) - quo_ext) : quo_ext;
                            end
                        end
                        MODE_EUCLID: begin
                            if (div_rem == '0) begin
                                r_mode <= MODE_SCALE;
                            end else begin
                                r_quo <= div_quo;
                                r_rem <= div_rem;
                            end
                        end
                        MODE_SCALE: begin
                            r_k <= div_quo;
                        end
                        default: begin
                            r_ok <= 1'b0;
                        end
                    endcase
                end
            end
            S_MT: begin
                r_sm_prev <= r_sm_cur;
                r_sm_cur  <= r_sm_prev + mul_prod[W-1:0];
            end
            S_UPD: begin
                r_tm_prev <= r_tm_cur;
                r_tm_cur  <= r_tm_prev + mul_prod[W-1:0];
                r_lo      <= r_rem;
                r_par     <= ~r_par;
            end
            S_MY: begin
                r_x <= x_neg ? (RW'(0) - prod_ext) : prod_ext;
            end
            S_MD: begin
                r_y  <= y_neg ? (RW'(0) - prod_ext) : prod_ext;
                r_ok <= 1'b1;
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    lds_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    lds_mul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul (
        .i_clk  (i_clk),
        .i_op_a (mul_a),
        .i_op_b (mul_b),
        .o_prod (mul_prod)
    );

    // handshake and result
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = (r_state == S_OUT);
    assign o_out.solvable = r_ok;
    assign o_out.sol_x    = r_x;
    assign o_out.sol_y    = r_y;

`ifndef SYNTHESIS
    // input and output sides are never open in the same cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    // an unsolvable item reports zero values
    a_zero_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.solvable) |-> (r_x == '0 && r_y == '0))
        else $error("nonzero values on an unsolvable item");

    // the next euclid divisor is never zero
    a_lo_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_rem != '0))
        else $error("euclid step with zero divisor");
`endif

endmodule

// ----- verif/tb_linear_diophantine_solver.sv -----
`timescale 1ns / 100ps

module tb_linear_diophantine_solver;

    localparam int DW           = lds_pkg::DATA_WIDTH_DEF;
    localparam int N_RANDOM     = 727;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 500;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_OFF     = 300;
    localparam int EUCLID_DEPTH = 64;
    localparam logic [31:0] MIN32 = 32'h8000_0000;
    localparam logic [31:0] MAX32 = 32'h7fff_ffff;

    // one row of the directed table
    typedef struct {
        lds_pkg::t_in  eqn;
        bit            known;
        lds_pkg::t_out want;
    } t_eqn_row;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          i_out_ready = 1'b0;
    lds_pkg::t_in  i_in        = '0;
    logic          o_in_ready;
    logic          o_out_valid;
    lds_pkg::t_out o_out;

    t_eqn_row      directed_eqns[$];
    lds_pkg::t_out pending_solutions[$];
    lds_pkg::t_out offered_want  = '0;
    bit            offered_known = 1'b0;
    int            mismatches    = 0;
    int            idle_cycles   = 0;
    int            results_taken = 0;

    linear_diophantine_solver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // low DW bits as two's complement
    function automatic longint to_operand(logic [31:0] raw);
        longint v;
        v = longint'(signed'(raw));
        v = (v <<< (64 - DW)) >>> (64 - DW);
        return v;
    endfunction

    // exact solution of a*x + b*y = n
    function automatic lds_pkg::t_out solve_diophantine(lds_pkg::t_in eqn);
        longint a, b, n, lo, hi, r, u, w, t, g, k, x, y;
        longint quo[EUCLID_DEPTH];
        int     depth;
        lds_pkg::t_out res;
        a = to_operand(eqn.coef_a);
        b = to_operand(eqn.coef_b);
        n = to_operand(eqn.target);
        x = 0;
        y = 0;
        res = '0;
        if (a == 0 && b == 0) begin
            res.solvable = (n == 0);
        end else if (a == 0) begin
            if (n % b == 0) begin
                res.solvable = 1'b1;
                y = n / b;
            end
        end else if (b == 0) begin
            if (n % a == 0) begin
                res.solvable = 1'b1;
                x = n / a;
            end
        end else begin
            // forward pass on the magnitudes, keeping the quotients
            lo = (a < 0) ? -a : a;
            hi = (b < 0) ? -b : b;
            depth = 0;
            while (lo != 0 && depth < EUCLID_DEPTH) begin
                r = hi % lo;
                quo[depth] = hi / lo;
                depth++;
                hi = lo;
                lo = r;
            end
            // back-substitution gives the bezout pair
            u = 0;
            w = 1;
            for (int i = depth - 1; i >= 0; i--) begin
                t = w - quo[i] * u;
                w = u;
                u = t;
            end
            g = hi;
            if (g != 0 && n % g == 0) begin
                k = n / g;
                res.solvable = 1'b1;
                x = u * k;
                y = w * k;
                if (a < 0) x = -x;
                if (b < 0) y = -y;
            end
        end
        res.sol_x = x;
        res.sol_y = y;
        return res;
    endfunction

    task automatic add_eqn(logic [31:0] a, logic [31:0] b, logic [31:0] n,
                           bit known, bit s, longint x, longint y);
        t_eqn_row row;
        row.eqn.coef_a      = a;
        row.eqn.coef_b      = b;
        row.eqn.target      = n;
        row.known           = known;
        row.want.solvable   = s;
        row.want.sol_x      = x;
        row.want.sol_y      = y;
        directed_eqns.push_back(row);
    endtask

    // mix of full range, near zero, zero, extremes, powers of two and values within a million
    function automatic logic [31:0] pick_value();
        int unsigned sel;
        logic [31:0] v;
        sel = $urandom_range(0, 9);
        case (sel) inside
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $urandom_range(0, 40) - 20;
            6:          v = '0;
            7: begin
                case ($urandom_range(0, 3))
                    0:       v = MIN32;
                    1:       v = MAX32;
                    2:       v = '1;
                    default: v = 32'd1;
                endcase
            end
            8: begin
                v = 32'd1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            default:    v = $urandom_range(0, 2_000_000) - 1_000_000;
        endcase
        return v;
    endfunction

    function automatic lds_pkg::t_in pick_equation();
        lds_pkg::t_in e;
        int unsigned g;
        if ($urandom_range(0, 9) < 4) begin
            // shared factor, target mostly a multiple of it
            g = $urandom_range(1, 5000);
            e.coef_a = g * ($urandom_range(0, 2000) - 1000);
            e.coef_b = g * ($urandom_range(0, 2000) - 1000);
            e.target = g * ($urandom_range(0, 2000) - 1000);
            if ($urandom_range(0, 3) == 0) e.target = e.target + $urandom_range(1, g);
        end else begin
            e.coef_a = pick_value();
            e.coef_b = pick_value();
            e.target = pick_value();
        end
        return e;
    endfunction

    // every third stretch of 40 items goes without gaps
    function automatic int draw_gap(int idx);
        return ((idx / 40) % 3 == 2) ? 0 : $urandom_range(0, 11);
    endfunction

    // offer one item and wait until it is taken
    task automatic offer_equation(lds_pkg::t_in eqn, bit known, lds_pkg::t_out want,
                                  int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in          <= eqn;
        offered_known <= known;
        offered_want  <= want;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // expected solutions in, results out and compared
    always @(posedge i_clk) begin : solution_check
        lds_pkg::t_out want;
        if (i_rst_n && i_in_valid && o_in_ready)
            pending_solutions.push_back(offered_known ? offered_want : solve_diophantine(i_in));
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_solutions.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: solvable=%0b x=%0d y=%0d",
                             o_out.solvable, o_out.sol_x, o_out.sol_y);
            end else begin
                want = pending_solutions.pop_front();
                if (o_out.solvable !== want.solvable || o_out.sol_x !== want.sol_x ||
                    o_out.sol_y !== want.sol_y) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected solvable=%0b x=%0d y=%0d, got %0b %0d %0d",
                                 want.solvable, want.sol_x, want.sol_y,
                                 o_out.solvable, o_out.sol_x, o_out.sol_y);
                end
            end
        end
    end

    // watchdog on cycles without any item moving
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_linear_diophantine_solver: done, errors");
                $finish;
            end
        end
    end

    // result side: random stalls, every third stretch of 40 results without stalls, plus two long hold-offs
    initial begin : result_sink
        int hold;
        wait (i_rst_n);
        forever begin
            hold = ((results_taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 11);
            if (results_taken == 3 || results_taken == 400) hold = HOLD_OFF;
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            results_taken++;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        lds_pkg::t_out no_answer;
        no_answer = '0;

        //       coef_a            coef_b            target      known solv x  y
        add_eqn(32'd0,            32'd0,            32'd0,           1, 1, 0, 0);
        add_eqn(32'd0,            32'd0,            32'd5,           1, 0, 0, 0);
        add_eqn(32'd0,            32'd0,            MIN32,           1, 0, 0, 0);
        add_eqn(32'd0,            32'd7,            32'd21,          1, 1, 0, 3);
        add_eqn(32'd0,            32'd7,            32'd22,          1, 0, 0, 0);
        add_eqn(32'd5,            32'd0,            -32'sd15,        1, 1, -3, 0);
        add_eqn(MIN32,            32'd0,            MIN32,           1, 1, 1, 0);
        add_eqn(32'd0,            '1,               MIN32,           1, 1, 0, 64'sd2147483648);
        add_eqn('1,               32'd0,            MIN32,           1, 1, 64'sd2147483648, 0);
        add_eqn(32'd0,            MIN32,            MIN32,           1, 1, 0, 1);
        add_eqn(32'd0,            MIN32,            32'd5,           1, 0, 0, 0);
        add_eqn(32'd6,            32'd4,            32'd3,           1, 0, 0, 0);
        add_eqn(MIN32,            MIN32,            MIN32,           1, 1, 1, 0);
        // euclid cases, answers from the predictor
        add_eqn(MAX32,            MAX32,            MAX32,           0, 0, 0, 0);
        add_eqn(MAX32,            32'd2147483646,   32'd1,           0, 0, 0, 0);
        add_eqn(32'd1836311903,   32'd1134903170,   32'd1,           0, 0, 0, 0);
        add_eqn(-32'sd1836311903, 32'd1134903170,   MIN32,           0, 0, 0, 0);
        add_eqn(32'd6,            -32'sd4,          32'd2,           0, 0, 0, 0);
        add_eqn('1,               '1,               MAX32,           0, 0, 0, 0);
        add_eqn(MIN32,            MAX32,            MIN32,           0, 0, 0, 0);
        add_eqn(32'd3,            32'd5,            32'd0,           0, 0, 0, 0);
        add_eqn('1,               '1,               '1,              0, 0, 0, 0);
        add_eqn(MIN32,            MAX32,            MAX32,           0, 0, 0, 0);

        // reset
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_eqns[i])
            offer_equation(directed_eqns[i].eqn, directed_eqns[i].known,
                           directed_eqns[i].want, draw_gap(i));
        for (int i = 0; i < N_RANDOM; i++)
            offer_equation(pick_equation(), 1'b0, no_answer, draw_gap(i + directed_eqns.size()));
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain, then watch for stray results
        while (pending_solutions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_solutions.size() == 0) begin
            $display("tb_linear_diophantine_solver: done, clean");
        end else begin
            $display("tb_linear_diophantine_solver: done, errors");
        end
        $finish;
    end

endmodule
